// ----- src/hrfp_pkg.sv -----
package hrfp_pkg;

   // ASCII codes that steer the tokenizer.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Token positions within a record line.
   localparam logic [2:0] TOK_SERIAL = 3'd0;
   localparam logic [2:0] TOK_TIME   = 3'd1;
   localparam logic [2:0] TOK_ORIENT = 3'd3;
   localparam logic [2:0] TOK_LON    = 3'd4;
   localparam logic [2:0] TOK_LAT    = 3'd5;
   localparam logic [2:0] TOK_LAST   = 3'd6;

   // Bits taken in per hex character.
   localparam int unsigned HEX_BITS = 4;

   // One parsed line, as delivered on the result channel.
   typedef struct packed {
      logic [63:0] serial_text;
      logic [3:0]  serial_length;
      logic [63:0] seconds;
      logic [63:0] microseconds;
      logic [63:0] orientation;
      logic [63:0] longitude;
      logic [63:0] latitude;
      logic [2:0]  token_count;
   } line_result_type;

   // Decodes one hex character; anything else counts as digit zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = 4'(c - 8'h57);
      end
      return d;
   endfunction

   // Shifts one hex digit into a 64-bit accumulator.
   function automatic logic [63:0] shift_in(input logic [63:0] acc, input logic [7:0] c);
      return {acc[63-HEX_BITS:0], hex_digit(c)};
   endfunction

endpackage

// ----- src/hex_record_field_parser.sv -----
// Channel  | Direction | Handshake           | Word
// req      | in        | req_valid/req_stall | one character, end-of-line flag
// rsp      | out       | rsp_valid/rsp_stall | parsed fields of one line
//
// One character is accepted per cycle while req_stall is low. A character is
// held in the input register; the line state is updated on the edge on which
// it moves on, and a line end loads the result register on that same edge, so
// a result passes the input register and then the result register. Reset is
// synchronous and clears the line state and both valids. A stalled result
// only holds back the input when the held character ends another line.
module hex_record_field_parser #(
   parameter int unsigned SERIAL_CHARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_line,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_serial_text,
   output logic [3:0]  rsp_serial_length,
   output logic [63:0] rsp_seconds,
   output logic [63:0] rsp_microseconds,
   output logic [63:0] rsp_orientation,
   output logic [63:0] rsp_longitude,
   output logic [63:0] rsp_latitude,
   output logic [2:0]  rsp_token_count
);

   logic                      in_valid_ff;
   logic [7:0]                in_char_ff;
   logic                      in_eol_ff;
   logic                      out_valid_ff;
   hrfp_pkg::line_result_type out_ff;
   hrfp_pkg::line_result_type line_next;
   logic                      step;

   // A held character moves on unless it ends a line and the result is blocked.
   assign step      = in_valid_ff && !(in_eol_ff && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         in_char_ff <= req_char_in;
         in_eol_ff  <= req_end_of_line;
      end
   end

   hrfp_line_state #(
      .SERIAL_CHARS(SERIAL_CHARS)
   ) u_line_state (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_in     (in_char_ff),
      .end_of_line (in_eol_ff),
      .line_out    (line_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && in_eol_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (step && in_eol_ff) begin
         out_ff <= line_next;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_serial_text   = out_ff.serial_text;
   assign rsp_serial_length = out_ff.serial_length;
   assign rsp_seconds       = out_ff.seconds;
   assign rsp_microseconds  = out_ff.microseconds;
   assign rsp_orientation   = out_ff.orientation;
   assign rsp_longitude     = out_ff.longitude;
   assign rsp_latitude      = out_ff.latitude;
   assign rsp_token_count   = out_ff.token_count;

endmodule

// ----- src/hrfp_line_state.sv -----
module hrfp_line_state #(
   parameter int unsigned SERIAL_CHARS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               char_in,
   input  logic                     end_of_line,
   output hrfp_pkg::line_result_type line_out
);

   logic [2:0]  token_index_ff,  token_index_in;
   logic [63:0] serial_store_ff, serial_store_in;
   logic [3:0]  serial_count_ff, serial_count_in;
   logic        colon_seen_ff,   colon_seen_in;
   logic [63:0] seconds_ff,      seconds_in;
   logic [63:0] micro_ff,        micro_in;
   logic [63:0] orient_ff,       orient_in;
   logic [63:0] lon_ff,          lon_in;
   logic [63:0] lat_ff,          lat_in;

   // Line state after taking in the current character.
   always_comb begin
      token_index_in  = token_index_ff;
      serial_store_in = serial_store_ff;
      serial_count_in = serial_count_ff;
      colon_seen_in   = colon_seen_ff;
      seconds_in      = seconds_ff;
      micro_in        = micro_ff;
      orient_in       = orient_ff;
      lon_in          = lon_ff;
      lat_in          = lat_ff;
      if (char_in == hrfp_pkg::CHAR_SPACE) begin
         if (token_index_ff < hrfp_pkg::TOK_LAST) begin
            token_index_in = token_index_ff + 3'd1;
         end
      end else begin
         unique case (token_index_ff)
            hrfp_pkg::TOK_SERIAL: begin
               if (serial_count_ff < 4'(SERIAL_CHARS) && serial_count_ff < 4'd8) begin
                  serial_store_in[serial_count_ff[2:0]*8 +: 8] = char_in;
                  serial_count_in = serial_count_ff + 4'd1;
               end
            end
            hrfp_pkg::TOK_TIME: begin
               if (!colon_seen_ff && char_in == hrfp_pkg::CHAR_COLON) begin
                  colon_seen_in = 1'b1;
                  micro_in      = '0;
               end else if (!colon_seen_ff) begin
                  seconds_in = hrfp_pkg::shift_in(seconds_ff, char_in);
                  micro_in   = hrfp_pkg::shift_in(micro_ff, char_in);
               end else begin
                  micro_in = hrfp_pkg::shift_in(micro_ff, char_in);
               end
            end
            hrfp_pkg::TOK_ORIENT: orient_in = hrfp_pkg::shift_in(orient_ff, char_in);
            hrfp_pkg::TOK_LON:    lon_in    = hrfp_pkg::shift_in(lon_ff, char_in);
            hrfp_pkg::TOK_LAT:    lat_in    = hrfp_pkg::shift_in(lat_ff, char_in);
            default: ;
         endcase
      end
   end

   // The finished line is the updated state.
   always_comb begin
      line_out.serial_text   = serial_store_in;
      line_out.serial_length = serial_count_in;
      line_out.seconds       = seconds_in;
      line_out.microseconds  = micro_in;
      line_out.orientation   = orient_in;
      line_out.longitude     = lon_in;
      line_out.latitude      = lat_in;
      line_out.token_count   = token_index_in + 3'd1;
   end

   // Commit the character, or clear everything once the line ends.
   always_ff @(posedge clock) begin
      if (reset || (step && end_of_line)) begin
         token_index_ff  <= '0;
         serial_store_ff <= '0;
         serial_count_ff <= '0;
         colon_seen_ff   <= 1'b0;
         seconds_ff      <= '0;
         micro_ff        <= '0;
         orient_ff       <= '0;
         lon_ff          <= '0;
         lat_ff          <= '0;
      end else if (step) begin
         token_index_ff  <= token_index_in;
         serial_store_ff <= serial_store_in;
         serial_count_ff <= serial_count_in;
         colon_seen_ff   <= colon_seen_in;
         seconds_ff      <= seconds_in;
         micro_ff        <= micro_in;
         orient_ff       <= orient_in;
         lon_ff          <= lon_in;
         lat_ff          <= lat_in;
      end
   end

endmodule
